// ----- hdl/gffc_pkg.sv -----
package gffc_pkg;

  // Cell bytes
  localparam logic [7:0] CHAR_FLOOR = 8'h2E;  // '.'
  localparam logic [7:0] CHAR_START = 8'h40;  // '@'

  localparam int DIM_W      = 6;   // grid_columns / grid_rows register width
  localparam int AREA_W     = 12;  // full product of two dimension values
  localparam int COUNT_W    = 11;  // reachable_count width
  localparam int OUT_DATA_W = 16;  // count padded to whole bytes
  localparam int CFG_IDX_W  = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b1;

  localparam logic [DIM_W-1:0] COLS_RESET = 6'd32;
  localparam logic [DIM_W-1:0] ROWS_RESET = 6'd32;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // cell word accepted
    logic check;   // test start, clear queue pointers
    logic split;   // one subtract step of start column recovery
    logic seed;    // enqueue start cell
    logic pop;     // read queue head
    logic fetch;   // capture dequeued cell
    logic nreq;    // probe current neighbor
    logic nchk;    // enqueue neighbor if still open
    logic finish;  // load result register, rearm for next grid
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic none;
    logic split_done;
    logic q_empty;
    logic nb_valid;
    logic last_dir;
    logic out_free;
  } sts_t;

  // Clamp a dimension register: zero acts as one, above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input int unsigned maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = DIM_W'(maxv);
    end
    return r;
  endfunction

endpackage

// ----- hdl/gffc_ram.sv -----
module gffc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/gffc_ctrl.sv -----
module gffc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  gffc_pkg::sts_t  sts_i,
  output gffc_pkg::cmd_t  cmd_o
);
  import gffc_pkg::*;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_SPLIT = 9'b000000100,
    S_SEED  = 9'b000001000,
    S_POP   = 9'b000010000,
    S_FETCH = 9'b000100000,
    S_NREQ  = 9'b001000000,
    S_NCHK  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.none ? S_DONE : S_SPLIT;
      end
      S_SPLIT: begin
        cmd_o.split = 1'b1;
        if (sts_i.split_done) begin
          state_d = S_SEED;
        end
      end
      S_SEED: begin
        cmd_o.seed = 1'b1;
        state_d    = S_POP;
      end
      S_POP: begin
        if (sts_i.q_empty) begin
          state_d = S_DONE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_NREQ;
      end
      S_NREQ: begin
        cmd_o.nreq = 1'b1;
        if (sts_i.nb_valid) begin
          state_d = S_NCHK;
        end else if (sts_i.last_dir) begin
          state_d = S_POP;
        end
      end
      S_NCHK: begin
        cmd_o.nchk = 1'b1;
        state_d    = sts_i.last_dir ? S_POP : S_NREQ;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/gffc_dp.sv -----
module gffc_dp #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gffc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gffc_pkg::DIM_W-1:0]          cfg_wdata_i,
  input  logic [7:0]                          cell_char_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [gffc_pkg::COUNT_W-1:0]        out_count_o,
  output logic                                out_no_start_o,
  input  gffc_pkg::cmd_t                      cmd_i,
  output gffc_pkg::sts_t                      sts_o
);
  import gffc_pkg::*;

  localparam int CAP = MAX_COLS * MAX_ROWS;
  localparam int IW  = $clog2(CAP);      // cell index
  localparam int LW  = $clog2(CAP + 1);  // counts up to CAP
  localparam int SW  = LW + 1;           // neighbor arithmetic headroom
  localparam int QW  = IW + DIM_W;       // queue word: {column, index}
  localparam int AREA_RST = int'(eff_dim(COLS_RESET, MAX_COLS))
                          * int'(eff_dim(ROWS_RESET, MAX_ROWS));

  // Configuration, held already clamped
  logic [DIM_W-1:0] cols_q, cols_d, rows_q, rows_d;
  logic [LW-1:0]    area_q, area_d;

  // Grid and search state
  logic [LW-1:0]    load_pos_q, load_pos_d;
  logic [IW-1:0]    start_q, start_d;
  logic             seen_q, seen_d;
  logic             none_q, none_d;
  logic [LW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [SW-1:0]    rem_q, rem_d;
  logic [IW-1:0]    cur_idx_q, cur_idx_d, nb_idx_q, nb_idx_d;
  logic [DIM_W-1:0] cur_col_q, cur_col_d, nb_col_q, nb_col_d;
  dir_e             dir_q, dir_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               no_start_q, no_start_d;

  // Memory ports
  logic          open_we, open_wdata, open_rdata;
  logic [IW-1:0] open_waddr, open_raddr;
  logic          q_we;
  logic [IW-1:0] q_waddr;
  logic [QW-1:0] q_wdata, q_rdata;

  // Neighbor candidate
  logic [SW-1:0]    idx_s, cols_s, area_s, lpos_s, nb_s;
  logic [DIM_W-1:0] nb_col;
  logic             cand_ok, nb_valid, none_now, split_done;
  logic             is_start, is_open;

  assign idx_s  = SW'(cur_idx_q);
  assign cols_s = SW'(cols_q);
  assign area_s = SW'(area_q);
  assign lpos_s = SW'(load_pos_q);

  always_comb begin
    cand_ok = 1'b0;
    nb_s    = idx_s;
    nb_col  = cur_col_q;
    case (dir_q)
      DIR_LEFT: begin
        cand_ok = cur_col_q != '0;
        nb_s    = idx_s - SW'(1);
        nb_col  = cur_col_q - DIM_W'(1);
      end
      DIR_RIGHT: begin
        cand_ok = ({1'b0, cur_col_q} + (DIM_W + 1)'(1)) < {1'b0, cols_q};
        nb_s    = idx_s + SW'(1);
        nb_col  = cur_col_q + DIM_W'(1);
      end
      DIR_UP: begin
        cand_ok = idx_s >= cols_s;
        nb_s    = idx_s - cols_s;
      end
      DIR_DOWN: begin
        cand_ok = (idx_s + cols_s) < area_s;
        nb_s    = idx_s + cols_s;
      end
      default: begin
        cand_ok = 1'b0;
      end
    endcase
  end

  // Cells not loaded in this grid are walls
  assign nb_valid   = cand_ok && (nb_s < lpos_s);
  assign none_now   = !seen_q || (SW'(start_q) >= area_s);
  assign split_done = rem_q < cols_s;
  assign is_start   = cell_char_i == CHAR_START;
  assign is_open    = is_start || (cell_char_i == CHAR_FLOOR);

  always_comb begin
    cols_d      = cols_q;
    rows_d      = rows_q;
    area_d      = area_q;
    load_pos_d  = load_pos_q;
    start_d     = start_q;
    seen_d      = seen_q;
    none_d      = none_q;
    head_d      = head_q;
    tail_d      = tail_q;
    rem_d       = rem_q;
    cur_idx_d   = cur_idx_q;
    cur_col_d   = cur_col_q;
    nb_idx_d    = nb_idx_q;
    nb_col_d    = nb_col_q;
    dir_d       = dir_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    no_start_d  = no_start_q;
    open_we     = 1'b0;
    open_waddr  = nb_idx_q;
    open_wdata  = 1'b0;
    q_we        = 1'b0;
    q_waddr     = tail_q[IW-1:0];
    q_wdata     = {nb_col_q, nb_idx_q};

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COLS: begin
          cols_d = eff_dim(cfg_wdata_i, MAX_COLS);
          area_d = LW'(AREA_W'(cols_d) * AREA_W'(rows_q));
        end
        REG_ROWS: begin
          rows_d = eff_dim(cfg_wdata_i, MAX_ROWS);
          area_d = LW'(AREA_W'(cols_q) * AREA_W'(rows_d));
        end
        default: begin
        end
      endcase
    end

    // Store the cell while the grid has room; extra cells only carry tlast
    if (cmd_i.load && (load_pos_q < area_q)) begin
      open_we    = 1'b1;
      open_waddr = load_pos_q[IW-1:0];
      open_wdata = is_open;
      if (is_start) begin
        start_d = load_pos_q[IW-1:0];
        seen_d  = 1'b1;
      end
      load_pos_d = load_pos_q + LW'(1);
    end

    if (cmd_i.check) begin
      none_d = none_now;
      head_d = '0;
      tail_d = '0;
      rem_d  = SW'(start_q);
    end

    if (cmd_i.split && !split_done) begin
      rem_d = rem_q - cols_s;
    end

    // Visited cells lose their open bit, so the map needs no clearing
    if (cmd_i.seed) begin
      open_we    = 1'b1;
      open_waddr = start_q;
      q_we       = 1'b1;
      q_waddr    = '0;
      q_wdata    = {DIM_W'(rem_q), start_q};
      tail_d     = LW'(1);
    end

    if (cmd_i.pop) begin
      head_d = head_q + LW'(1);
    end

    if (cmd_i.fetch) begin
      cur_idx_d = q_rdata[IW-1:0];
      cur_col_d = q_rdata[QW-1:IW];
      dir_d     = DIR_LEFT;
    end

    if (cmd_i.nreq) begin
      if (nb_valid) begin
        nb_idx_d = nb_s[IW-1:0];
        nb_col_d = nb_col;
      end else begin
        dir_d = dir_e'(dir_q + 2'd1);
      end
    end

    if (cmd_i.nchk) begin
      if (open_rdata) begin
        open_we = 1'b1;
        q_we    = 1'b1;
        tail_d  = tail_q + LW'(1);
      end
      dir_d = dir_e'(dir_q + 2'd1);
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      count_d     = COUNT_W'(tail_q);
      no_start_d  = none_q;
      load_pos_d  = '0;
      seen_d      = 1'b0;
      start_d     = '0;
      head_d      = '0;
      tail_d      = '0;
    end
  end

  assign open_raddr = nb_s[IW-1:0];

  gffc_ram #(
    .WIDTH(1),
    .DEPTH(CAP)
  ) u_open_map (
    .clk_i  (clk_i),
    .we_i   (open_we),
    .waddr_i(open_waddr),
    .wdata_i(open_wdata),
    .raddr_i(open_raddr),
    .rdata_o(open_rdata)
  );

  gffc_ram #(
    .WIDTH(QW),
    .DEPTH(CAP)
  ) u_queue (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(q_waddr),
    .wdata_i(q_wdata),
    .raddr_i(head_q[IW-1:0]),
    .rdata_o(q_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= eff_dim(COLS_RESET, MAX_COLS);
      rows_q      <= eff_dim(ROWS_RESET, MAX_ROWS);
      area_q      <= LW'(AREA_RST);
      load_pos_q  <= '0;
      start_q     <= '0;
      seen_q      <= 1'b0;
      none_q      <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      dir_q       <= DIR_LEFT;
      out_valid_q <= 1'b0;
    end else begin
      cols_q      <= cols_d;
      rows_q      <= rows_d;
      area_q      <= area_d;
      load_pos_q  <= load_pos_d;
      start_q     <= start_d;
      seen_q      <= seen_d;
      none_q      <= none_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    cur_idx_q  <= cur_idx_d;
    cur_col_q  <= cur_col_d;
    nb_idx_q   <= nb_idx_d;
    nb_col_q   <= nb_col_d;
    count_q    <= count_d;
    no_start_q <= no_start_d;
  end

  assign sts_o.none       = none_now;
  assign sts_o.split_done = split_done;
  assign sts_o.q_empty    = head_q == tail_q;
  assign sts_o.nb_valid   = nb_valid;
  assign sts_o.last_dir   = dir_q == DIR_DOWN;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_count_o    = count_q;
  assign out_no_start_o = no_start_q;

  // Queue never reads past its tail
  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed tail");

  // Each enqueued cell was loaded in this grid and is taken once
  a_tail_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= load_pos_q)
    else $error("more cells enqueued than loaded");

  a_result_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.finish))
    else $error("result appeared without finish");

  a_no_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && no_start_q) |-> (count_q == '0))
    else $error("no-start result with nonzero count");

  a_seed_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.seed |-> (!none_q && seen_q))
    else $error("seed without a usable start");

endmodule

// ----- hdl/grid_flood_fill_counter.sv -----
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] cell_char, tlast last_cell
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[10:0] reachable_count, tuser no_start
// cfg       in   cfg_we_i (no wait)           cfg_idx_i register, cfg_wdata_i value
//
// Cells load at one word per cycle; after the tlast word input stalls for the search:
// a check step, start column recovery by repeated subtraction, a seed step, then per
// reached cell a pop, a fetch and per direction a probe plus, for a valid neighbor, an
// open map check; an empty queue ends the search and the result posts. Reset needs no
// clearing pass: visited cells drop their open bit, each grid rewrites the map. A
// stalled result holds while the next grid loads; only a finished search waits.
module grid_flood_fill_counter #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [gffc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gffc_pkg::DIM_W-1:0]           cfg_wdata_i,
  // Cell stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,   // [7:0] cell_char
  input  logic                                 s_axis_tlast,
  // Result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [gffc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // [10:0] reachable_count
  output logic                                 m_axis_tuser    // [0] no_start
);
  import gffc_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [COUNT_W-1:0] count;

  // Sequence the load, search and result phases
  gffc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_last_i (s_axis_tlast),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Hold config, maps, queue and the result register
  gffc_dp #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cell_char_i   (s_axis_tdata),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_count_o   (count),
    .out_no_start_o(m_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  // Pad the count to whole bytes
  assign m_axis_tdata = OUT_DATA_W'(count);

endmodule
